[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ncdf_pkg.sv]
`timescale 1ns / 1ps
package ncdf_pkg;

    typedef struct packed {
        logic valid;
        logic neg;
        logic far;
    } ncdf_tag_t;

    localparam logic [15:0] LIMIT_Q12     = 16'd20480;
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
    localparam logic [31:0] HALF_Q30      = 32'd536870912;
    localparam logic [31:0] A6_Q30        = 32'd46239;

    localparam int HORNER_STEPS = 6;
    localparam int DIV_STEPS    = 31;
    localparam int SQ_STEPS     = 4;

    // Constant added after each Horner multiply: a5, a4, a3, a2, a1, then 1.0
    localparam logic [31:0] HORNER_ADD [HORNER_STEPS] = '{
        32'd296962, 32'd163224, 32'd9954153, 32'd45399965, 32'd75723579, 32'd1073741824
    };

endpackage

[design/ncdf_poly.sv]
`timescale 1ns / 1ps
module ncdf_poly
    import ncdf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [15:0]      sample_value,
    output ncdf_tag_t        out_tag,
    output logic [31:0]      out_p
);

    logic              neg;
    logic [15:0]       mag;
    ncdf_tag_t         tag0_next;
    ncdf_tag_t         tag0_reg;
    logic [14:0]       mag0_reg;
    logic [46:0]       yprod;
    logic [31:0]       y_next;
    logic [31:0]       y_reg;
    ncdf_tag_t         ytag_reg;

    ncdf_tag_t         htag_reg [HORNER_STEPS];
    logic [31:0]       acc_reg  [HORNER_STEPS];
    logic [31:0]       acc_next [HORNER_STEPS];
    logic [31:0]       hy_reg   [HORNER_STEPS];

    always_comb
    begin
        neg             = sample_value[15];
        mag             = neg ? (16'd0 - sample_value) : sample_value;
        tag0_next.valid = in_valid;
        tag0_next.neg   = neg;
        tag0_next.far   = (mag > LIMIT_Q12);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            ytag_reg <= '0;
        end
        else if (adv)
        begin
            tag0_reg <= tag0_next;
            ytag_reg <= tag0_reg;
        end
    end

    // y = |u| / sqrt(2) in Q30, rounded
    assign yprod  = {32'd0, mag0_reg} * {15'd0, INV_SQRT2_Q32};
    assign y_next = 32'((yprod + 47'd8192) >> 14);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag0_reg <= mag[14:0];
            y_reg    <= y_next;
        end
    end

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        logic [31:0] acc_in;
        logic [31:0] y_in;
        ncdf_tag_t   tag_in;
        logic [63:0] prod;
        logic [33:0] rnd;

        if (k == 0)
        begin : g_first
            assign acc_in = A6_Q30;
            assign y_in   = y_reg;
            assign tag_in = ytag_reg;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[k-1];
            assign y_in   = hy_reg[k-1];
            assign tag_in = htag_reg[k-1];
        end

        assign prod        = {32'd0, acc_in} * {32'd0, y_in};
        assign rnd         = 34'((prod + {32'd0, HALF_Q30}) >> 30);
        assign acc_next[k] = 32'(rnd + {2'd0, HORNER_ADD[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                htag_reg[k] <= '0;
            end
            else if (adv)
            begin
                htag_reg[k] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                acc_reg[k] <= acc_next[k];
                hy_reg[k]  <= y_in;
            end
        end
    end

    assign out_tag = htag_reg[HORNER_STEPS-1];
    assign out_p   = acc_reg[HORNER_STEPS-1];

endmodule

[design/ncdf_recip.sv]
`timescale 1ns / 1ps
module ncdf_recip
    import ncdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  ncdf_tag_t   in_tag,
    input  logic [31:0] in_p,
    output ncdf_tag_t   out_tag,
    output logic [30:0] out_r
);

    // Restoring division of (2^60 + p/2) by p, one quotient bit per stage.
    // The top bits of the dividend reduce to a start remainder of 2^29;
    // the low bits are p[31:1], shifted in MSB first.
    ncdf_tag_t   tag_reg [DIV_STEPS];
    logic [31:0] rem_reg [DIV_STEPS];
    logic [30:0] q_reg   [DIV_STEPS];
    logic [31:0] p_reg   [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        ncdf_tag_t   tag_in;
        logic [31:0] rem_in;
        logic [30:0] q_in;
        logic [31:0] p_in;
        logic [32:0] trial;
        logic        ge;
        logic [31:0] rem_next;
        logic [30:0] q_next;

        if (i == 0)
        begin : g_first
            assign tag_in = in_tag;
            assign rem_in = 32'd536870912;
            assign q_in   = '0;
            assign p_in   = in_p;
        end
        else
        begin : g_rest
            assign tag_in = tag_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign p_in   = p_reg[i-1];
        end

        assign trial    = {rem_in, p_in[31-i]};
        assign ge       = (trial >= {1'b0, p_in});
        assign rem_next = ge ? 32'(trial - {1'b0, p_in}) : trial[31:0];
        assign q_next   = {q_in[29:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i] <= '0;
            end
            else if (adv)
            begin
                tag_reg[i] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= rem_next;
                q_reg[i]   <= q_next;
                p_reg[i]   <= p_in;
            end
        end
    end

    assign out_tag = tag_reg[DIV_STEPS-1];
    assign out_r   = q_reg[DIV_STEPS-1];

endmodule

[design/ncdf_pow.sv]
`timescale 1ns / 1ps
module ncdf_pow
    import ncdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  ncdf_tag_t   in_tag,
    input  logic [30:0] in_r,
    output ncdf_tag_t   out_tag,
    output logic [15:0] out_prob
);

    ncdf_tag_t   tag_reg [SQ_STEPS];
    logic [30:0] t_reg   [SQ_STEPS];

    logic [31:0] hsum;
    logic [15:0] half;
    logic [16:0] upper;
    logic [15:0] prob_next;
    logic [15:0] prob_reg;
    ncdf_tag_t   otag_reg;

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_sq
        ncdf_tag_t   tag_in;
        logic [30:0] r_in;
        logic [61:0] sq;

        if (s == 0)
        begin : g_first
            assign tag_in = in_tag;
            assign r_in   = in_r;
        end
        else
        begin : g_rest
            assign tag_in = tag_reg[s-1];
            assign r_in   = t_reg[s-1];
        end

        assign sq = {31'd0, r_in} * {31'd0, r_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s] <= '0;
            end
            else if (adv)
            begin
                tag_reg[s] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                t_reg[s] <= 31'((sq + {30'd0, HALF_Q30}) >> 30);
            end
        end
    end

    // half tail in Q16; upper side is 1 - half, saturated at full scale
    always_comb
    begin
        hsum  = {1'b0, t_reg[SQ_STEPS-1]} + 32'd16384;
        half  = hsum[30:15];
        upper = 17'h10000 - {1'b0, half};
        if (tag_reg[SQ_STEPS-1].far)
        begin
            prob_next = tag_reg[SQ_STEPS-1].neg ? 16'd0 : 16'hFFFF;
        end
        else if (tag_reg[SQ_STEPS-1].neg)
        begin
            prob_next = half;
        end
        else if (upper[16])
        begin
            prob_next = 16'hFFFF;
        end
        else
        begin
            prob_next = upper[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            otag_reg <= '0;
        end
        else if (adv)
        begin
            otag_reg <= tag_reg[SQ_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prob_reg <= prob_next;
        end
    end

    assign out_tag  = otag_reg;
    assign out_prob = prob_reg;

endmodule

[design/normal_cdf_approximation.sv]
`timescale 1ns / 1ps
// Standard normal CDF: P(X < u) for a signed Q4.12 sample u, as unsigned Q0.16.
// Input channel: sample_value with sample_valid / sample_stall; a transfer
// happens on a rising edge with valid high and stall low.
// Output channel: probability with probability_valid / probability_stall,
// same rule.
// Pipeline, in order: input register, the y multiply, six Horner stages,
// a 31-stage bit-per-stage reciprocal, four squaring stages and the output
// register. Throughput: one sample per cycle while the output is not
// stalled. Each Horner, reciprocal and squaring stage is a single multiply
// or a single compare-subtract, and valid bits travel with the data.
// Samples below -5 give 0, above 5 give 65535; 1.0 saturates to 65535.
// Reset clears all valid bits; the pipe comes up empty and ready.
// When the receiver stalls a valid result, the whole pipeline holds and
// sample_stall goes high; no result is lost or repeated. While the output
// register is empty the pipe keeps advancing.
`include "assert_macros.svh"
module normal_cdf_approximation
    import ncdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [15:0] sample_value,
    output logic        probability_valid,
    input  logic        probability_stall,
    output logic [15:0] probability
);

    logic        adv;
    ncdf_tag_t   p_tag;
    logic [31:0] p_val;
    ncdf_tag_t   r_tag;
    logic [30:0] r_val;
    ncdf_tag_t   o_tag;
    logic [37:0] mid_state;
    logic        side_ok;
    logic        clamp_ok;

    // hold everything only while a finished result waits
    assign adv          = !(probability_valid && probability_stall);
    assign sample_stall = !adv;

    ncdf_poly u_poly (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (sample_valid),
        .sample_value (sample_value),
        .out_tag      (p_tag),
        .out_p        (p_val)
    );

    ncdf_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_tag  (p_tag),
        .in_p    (p_val),
        .out_tag (r_tag),
        .out_r   (r_val)
    );

    ncdf_pow u_pow (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_tag   (r_tag),
        .in_r     (r_val),
        .out_tag  (o_tag),
        .out_prob (probability)
    );

    assign probability_valid = o_tag.valid;

    assign mid_state = {p_tag, p_val, r_tag};
    assign side_ok   = o_tag.neg ? (probability <= 16'd32768) : (probability >= 16'd32768);
    assign clamp_ok  = (probability == (o_tag.neg ? 16'd0 : 16'hFFFF));

    `ASSERT_NEXT(a_freeze, !adv, $stable(mid_state), "pipeline moved while output stalled")
    `ASSERT_ALWAYS(a_side, probability_valid && !o_tag.far, side_ok, "result on wrong side")
    `ASSERT_ALWAYS(a_far, probability_valid && o_tag.far, clamp_ok, "far sample not clamped")

endmodule
